FILE: hw/rtl/rsi_pkg.sv
// Package for the ray/sphere intersection core: widths, defaults and shared types.
// Used by every module under hw/rtl; depends on nothing.
package rsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH     = 4;

   // Configuration register indexes.
   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   // Status that travels with each item from the front end to the back end.
   typedef struct packed {
      logic zero_dir;
      logic neg_disc;
   } rsi_flags_type;

endpackage

FILE: hw/rtl/rsi_front.sv
// Front end: forms L, a, h, c and the discriminant in a registered pipeline.
// Depends on rsi_pkg.
module rsi_front #(
   parameter int CW = rsi_pkg::COORD_WIDTH_DEF,
   parameter int AW = 2 * CW + 4,
   parameter int DW = 4 * CW + 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [CW-1:0] ox, oy, oz, dx, dy, dz,
   input  logic signed [CW-1:0] cx, cy, cz,
   input  logic [CW-2:0]        rad,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [AW-1:0] out_a, out_h, out_c,
   output logic signed [DW-1:0] out_disc,
   output rsi_pkg::rsi_flags_type out_flags
);
   localparam int LW = CW + 1;
   localparam int HW = AW / 2;
   localparam int PW = 2 * HW + 2;

   // Stage valids; the pipe advances as a whole when the tail can move.
   logic [4:0] v_ff, v_in;
   logic       adv;
   assign adv      = !v_ff[4] || out_ready;
   assign in_ready = adv;

   // Stage 1: differences and copies.
   logic signed [LW-1:0] l_ff [3];
   logic signed [CW-1:0] d_ff [3];
   logic [CW-2:0]        r_ff;
   // Stage 2: products and sums.
   logic signed [AW-1:0] a_ff, h_ff, c_ff;
   // Stage 3: half-width partial products of h*h and a*c.
   logic signed [PW-1:0] hhh_ff, hhl_ff, hll_ff;
   logic signed [PW-1:0] ahh_ff, ahl_ff, alh_ff, all_ff;
   // Stage 4: h*h and a*c at full width.
   logic signed [DW-1:0] hsq_ff, ac_ff;
   // Stage 5: discriminant.
   logic signed [DW-1:0] disc_ff;
   // Copies of a, h and c that ride along stages 3 to 5.
   logic signed [AW-1:0] ad_ff [3], hd_ff [3], cd_ff [3];

   // Upper halves keep the sign; lower halves are taken as positive values.
   logic signed [HW:0] h_hi, h_lo, a_hi, a_lo, c_hi, c_lo;
   assign h_hi = (HW+1)'($signed(h_ff[AW-1:HW]));
   assign h_lo = $signed({1'b0, h_ff[HW-1:0]});
   assign a_hi = (HW+1)'($signed(a_ff[AW-1:HW]));
   assign a_lo = $signed({1'b0, a_ff[HW-1:0]});
   assign c_hi = (HW+1)'($signed(c_ff[AW-1:HW]));
   assign c_lo = $signed({1'b0, c_ff[HW-1:0]});

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff[0] <= LW'(ox) - LW'(cx);
         l_ff[1] <= LW'(oy) - LW'(cy);
         l_ff[2] <= LW'(oz) - LW'(cz);
         d_ff[0] <= dx;
         d_ff[1] <= dy;
         d_ff[2] <= dz;
         r_ff    <= rad;
         a_ff <= AW'(d_ff[0] * d_ff[0]) + AW'(d_ff[1] * d_ff[1]) + AW'(d_ff[2] * d_ff[2]);
         h_ff <= AW'(d_ff[0] * l_ff[0]) + AW'(d_ff[1] * l_ff[1]) + AW'(d_ff[2] * l_ff[2]);
         c_ff <= AW'(l_ff[0] * l_ff[0]) + AW'(l_ff[1] * l_ff[1]) + AW'(l_ff[2] * l_ff[2])
                 - AW'({1'b0, r_ff} * {1'b0, r_ff});
         hhh_ff <= PW'(h_hi * h_hi);
         hhl_ff <= PW'(h_hi * h_lo);
         hll_ff <= PW'(h_lo * h_lo);
         ahh_ff <= PW'(a_hi * c_hi);
         ahl_ff <= PW'(a_hi * c_lo);
         alh_ff <= PW'(a_lo * c_hi);
         all_ff <= PW'(a_lo * c_lo);
         hsq_ff <= (DW'(hhh_ff) <<< (2 * HW)) + (DW'(hhl_ff) <<< (HW + 1)) + DW'(hll_ff);
         ac_ff  <= (DW'(ahh_ff) <<< (2 * HW)) + ((DW'(ahl_ff) + DW'(alh_ff)) <<< HW)
                   + DW'(all_ff);
         disc_ff <= hsq_ff - ac_ff;
         ad_ff[0] <= a_ff;
         ad_ff[1] <= ad_ff[0];
         ad_ff[2] <= ad_ff[1];
         hd_ff[0] <= h_ff;
         hd_ff[1] <= hd_ff[0];
         hd_ff[2] <= hd_ff[1];
         cd_ff[0] <= c_ff;
         cd_ff[1] <= cd_ff[0];
         cd_ff[2] <= cd_ff[1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (adv) v_in = {v_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   assign out_valid          = v_ff[4];
   assign out_a              = ad_ff[2];
   assign out_h              = hd_ff[2];
   assign out_c              = cd_ff[2];
   assign out_disc           = disc_ff;
   assign out_flags.zero_dir = (ad_ff[2] == '0);
   assign out_flags.neg_disc = disc_ff[DW-1];
endmodule

FILE: hw/rtl/rsi_queue.sv
// Short queue that parts the front end from the back end.
// Depends on rsi_pkg.
module rsi_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rsi_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PW = $clog2(DEPTH);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [PW:0]      cnt_ff;
   logic             push, pop;

   assign in_ready  = (cnt_ff != (PW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rp_ff];

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end
endmodule

FILE: hw/rtl/rsi_back.sv
// Back end: square root, root divisions, ordering and saturation, pipelined.
// Depends on rsi_pkg.
module rsi_back #(
   parameter int CW = rsi_pkg::COORD_WIDTH_DEF,
   parameter int FB = rsi_pkg::FRAC_BITS_DEF,
   parameter int AW = 2 * CW + 4,
   parameter int DW = 4 * CW + 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [AW-1:0] in_a, in_h, in_c,
   input  logic signed [DW-1:0] in_disc,
   input  rsi_pkg::rsi_flags_type in_flags,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_hit,
   output logic signed [CW-1:0] out_dist
);
   // Widths: root, q, dividends and quotients.
   localparam int SW  = DW / 2;
   localparam int QW  = AW + 2;
   localparam int NW  = QW + FB;
   localparam int SQN = SW;           // one result bit per root stage
   localparam int DVN = NW;           // one quotient bit per divide stage
   localparam int NS  = SQN + 1 + DVN + 1;

   logic adv;
   assign adv      = !out_valid || out_ready;
   assign in_ready = adv;

   // Root stages: remainder, partial root and carried operands.
   logic [DW-1:0]        srem [SQN+1];
   logic [SW-1:0]        sres [SQN+1];
   logic [DW-1:0]        srad [SQN+1];
   logic signed [AW-1:0] sa [SQN+1], sh [SQN+1], sc [SQN+1];
   logic                 smiss [SQN+1];
   logic [NS-1:0]        v_ff;

   assign srad[0]  = in_disc;
   assign srem[0]  = '0;
   assign sres[0]  = '0;
   assign sa[0]    = in_a;
   assign sh[0]    = in_h;
   assign sc[0]    = in_c;
   assign smiss[0] = in_flags.zero_dir || in_flags.neg_disc;

   // Digit-by-digit root, two radicand bits per stage.
   for (genvar k = 0; k < SQN; k++) begin : g_sqrt
      logic [DW-1:0] rem_w, trial;
      logic [DW-1:0] rad_r, rem_r;
      logic [SW-1:0] res_r;
      logic signed [AW-1:0] a_r, h_r, c_r;
      logic m_r;
      always_comb begin
         rem_w = {srem[k][DW-3:0], srad[k][2*SQN-1-2*k -: 2]};
         trial = DW'({sres[k], 2'b01});
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_w >= trial) begin
               rem_r <= rem_w - trial;
               res_r <= {sres[k][SW-2:0], 1'b1};
            end else begin
               rem_r <= rem_w;
               res_r <= {sres[k][SW-2:0], 1'b0};
            end
            rad_r <= srad[k];
            a_r <= sa[k]; h_r <= sh[k]; c_r <= sc[k]; m_r <= smiss[k];
         end
      end
      assign srem[k+1] = rem_r;
      assign sres[k+1] = res_r;
      assign srad[k+1] = rad_r;
      assign sa[k+1] = a_r; assign sh[k+1] = h_r; assign sc[k+1] = c_r;
      assign smiss[k+1] = m_r;
   end

   // Stage after the root: q, dividends, divisors and signs.
   logic [NW-1:0] n0_ff, n1_ff, d0_ff, d1_ff;
   logic          ng0_ff, ng1_ff, qm_ff;
   always_ff @(posedge clock) begin
      logic signed [QW-1:0] q, s, h;
      logic signed [NW-1:0] nq, nc;
      h = QW'(sh[SQN]);
      s = QW'($signed({1'b0, sres[SQN]}));
      q = h[QW-1] ? s - h : -(h + s);
      nq = NW'(q) <<< FB;
      nc = NW'(sc[SQN]) <<< FB;
      if (adv) begin
         qm_ff  <= smiss[SQN] || (q == '0);
         n0_ff  <= nq[NW-1] ? NW'(-nq) : NW'(nq);
         d0_ff  <= NW'(sa[SQN]);
         ng0_ff <= nq[NW-1];
         n1_ff  <= nc[NW-1] ? NW'(-nc) : NW'(nc);
         d1_ff  <= q[QW-1] ? NW'(-q) : NW'(q);
         ng1_ff <= nc[NW-1] ^ q[QW-1];
      end
   end

   // Two restoring dividers in lockstep, one quotient bit per stage.
   logic [NW-1:0] xq0 [DVN+1], xq1 [DVN+1], rr0 [DVN+1], rr1 [DVN+1];
   logic [NW-1:0] dd0 [DVN+1], dd1 [DVN+1];
   logic          gg0 [DVN+1], gg1 [DVN+1], mm [DVN+1];
   assign xq0[0] = n0_ff; assign xq1[0] = n1_ff;
   assign rr0[0] = '0;    assign rr1[0] = '0;
   assign dd0[0] = d0_ff; assign dd1[0] = d1_ff;
   assign gg0[0] = ng0_ff; assign gg1[0] = ng1_ff; assign mm[0] = qm_ff;

   for (genvar k = 0; k < DVN; k++) begin : g_div
      logic [NW:0] t0, t1;
      logic [NW-1:0] xq0_r, xq1_r, rr0_r, rr1_r, dd0_r, dd1_r;
      logic g0_r, g1_r, m_r;
      assign t0 = {rr0[k], xq0[k][NW-1]};
      assign t1 = {rr1[k], xq1[k][NW-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            if (t0 >= {1'b0, dd0[k]}) begin
               rr0_r <= NW'(t0 - {1'b0, dd0[k]});
               xq0_r <= {xq0[k][NW-2:0], 1'b1};
            end else begin
               rr0_r <= NW'(t0);
               xq0_r <= {xq0[k][NW-2:0], 1'b0};
            end
            if (t1 >= {1'b0, dd1[k]}) begin
               rr1_r <= NW'(t1 - {1'b0, dd1[k]});
               xq1_r <= {xq1[k][NW-2:0], 1'b1};
            end else begin
               rr1_r <= NW'(t1);
               xq1_r <= {xq1[k][NW-2:0], 1'b0};
            end
            dd0_r <= dd0[k]; dd1_r <= dd1[k];
            g0_r <= gg0[k]; g1_r <= gg1[k]; m_r <= mm[k];
         end
      end
      assign xq0[k+1] = xq0_r; assign xq1[k+1] = xq1_r;
      assign rr0[k+1] = rr0_r; assign rr1[k+1] = rr1_r;
      assign dd0[k+1] = dd0_r; assign dd1[k+1] = dd1_r;
      assign gg0[k+1] = g0_r; assign gg1[k+1] = g1_r; assign mm[k+1] = m_r;
   end

   // Final stage: floor sign fix, ordering, selection and saturation.
   logic                 hit_ff;
   logic signed [CW-1:0] dist_ff;
   always_ff @(posedge clock) begin
      logic signed [NW:0] t0, t1, lo, hi, t;
      logic [NW:0] mag0, mag1;
      mag0 = {1'b0, xq0[DVN]};
      mag1 = {1'b0, xq1[DVN]};
      t0 = gg0[DVN] ? -$signed(mag0) - $signed((NW+1)'(rr0[DVN] != '0))
                    : $signed(mag0);
      t1 = gg1[DVN] ? -$signed(mag1) - $signed((NW+1)'(rr1[DVN] != '0))
                    : $signed(mag1);
      lo = (t0 > t1) ? t1 : t0;
      hi = (t0 > t1) ? t0 : t1;
      t  = lo[NW] ? hi : lo;
      if (adv) begin
         if (mm[DVN] || hi[NW]) begin
            hit_ff  <= 1'b0;
            dist_ff <= -$signed(CW'(1) << FB);
         end else begin
            hit_ff  <= 1'b1;
            dist_ff <= (t > $signed((NW+1)'({1'b0, {(CW-1){1'b1}}})))
                       ? $signed({1'b0, {(CW-1){1'b1}}}) : CW'(t);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], in_valid};
   end

   assign out_valid = v_ff[NS-1];
   assign out_hit   = hit_ff;
   assign out_dist  = dist_ff;
endmodule

FILE: hw/rtl/ray_sphere_intersect_core.sv
// Channel | Dir | Payload
// req     | in  | tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// rsp     | out | tdata: hit (bit 0), hit_distance (bits 32:1), zero fill
// csr     | in  | index 0..3 = center_x, center_y, center_z, sphere_radius
// One ray is accepted per cycle, back to back, while rsp_tready stays high.
// With 32-bit coordinates and 16 fraction bits a ray passes, in order, 5 front stages,
// the queue storage, 69 root stages, 1 q stage, 86 divide stages and 1 output stage
// before rsp_tvalid rises. A low rsp_tready freezes the back end; the 4-entry queue
// then fills and req_tready drops once the last front stage holds an item.
// Reset is synchronous, clears all valids and sets the center to 0, radius 1.0.
// Top level of the ray/sphere intersection core; depends on rsi_pkg,
// rsi_front, rsi_queue and rsi_back.
module ray_sphere_intersect_core #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, from bit 0 up
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // hit, hit_distance, from bit 0 up
   output logic [((COORD_WIDTH+8)/8)*8-1:0] rsp_tdata,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [COORD_WIDTH-1:0]      csr_wdata
);
   localparam int CW  = COORD_WIDTH;
   localparam int AW  = 2 * CW + 4;
   localparam int DW  = 4 * CW + 10;
   localparam int QDW = 3 * AW + DW + 2;
   localparam int OTW = ((CW + 8) / 8) * 8;

   // Sphere registers.
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;
   logic [CW-2:0]        rad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= (CW-1)'(1) << FRAC_BITS;
      end else if (csr_we) begin
         case (csr_index)
            rsi_pkg::REG_CENTER_X: cx_ff  <= csr_wdata;
            rsi_pkg::REG_CENTER_Y: cy_ff  <= csr_wdata;
            rsi_pkg::REG_CENTER_Z: cz_ff  <= csr_wdata;
            rsi_pkg::REG_RADIUS:   rad_ff <= csr_wdata[CW-2:0];
            default: ;
         endcase
      end
   end

   logic                 f_valid, f_ready;
   logic signed [AW-1:0] f_a, f_h, f_c;
   logic signed [DW-1:0] f_disc;
   rsi_pkg::rsi_flags_type f_flags;

   rsi_front #(.CW(CW), .AW(AW), .DW(DW)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .ox(req_tdata[0*CW +: CW]), .oy(req_tdata[1*CW +: CW]), .oz(req_tdata[2*CW +: CW]),
      .dx(req_tdata[3*CW +: CW]), .dy(req_tdata[4*CW +: CW]), .dz(req_tdata[5*CW +: CW]),
      .cx(cx_ff), .cy(cy_ff), .cz(cz_ff), .rad(rad_ff),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_a(f_a), .out_h(f_h), .out_c(f_c), .out_disc(f_disc), .out_flags(f_flags)
   );

   logic           q_valid, q_ready;
   logic [QDW-1:0] q_data;
   rsi_queue #(.WIDTH(QDW), .DEPTH(rsi_pkg::QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_flags, f_disc, f_c, f_h, f_a}),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   rsi_pkg::rsi_flags_type b_flags;
   logic                   b_hit;
   logic signed [CW-1:0]   b_dist;
   assign b_flags = q_data[QDW-1 -: 2];

   rsi_back #(.CW(CW), .FB(FRAC_BITS), .AW(AW), .DW(DW)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready),
      .in_a(q_data[0 +: AW]), .in_h(q_data[AW +: AW]), .in_c(q_data[2*AW +: AW]),
      .in_disc(q_data[3*AW +: DW]), .in_flags(b_flags),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_hit(b_hit), .out_dist(b_dist)
   );

   assign rsp_tdata = OTW'({b_dist, b_hit});
endmodule

FILE: hw/rtl/rsi_checker.sv
// Port-level checker for the ray/sphere intersection core, bound to the top.
// Depends on rsi_pkg for default widths.
module rsi_checker #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((COORD_WIDTH+8)/8)*8-1:0]   rsp_tdata
);
   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // A miss always carries minus one.
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |->
         rsp_tdata[COORD_WIDTH:1] == COORD_WIDTH'(-(64'sd1 <<< FRAC_BITS)))
      else $error("miss without minus one");
   // A hit never reports a negative distance.
   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[COORD_WIDTH])
      else $error("negative hit distance");
   // Nothing comes out right after reset.
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind ray_sphere_intersect_core rsi_checker #(.COORD_WIDTH(COORD_WIDTH),
   .FRAC_BITS(FRAC_BITS)) u_rsi_checker (.*);
